FILE: sv/grc_pkg.sv
// Shared types and constants of the grid raycast column unit.
`timescale 1ns / 1ps
package grc_pkg;
  localparam int FRAC_BITS = 16;
  localparam int POS_W = 22;
  localparam int DIR_W = 18;
  localparam int COL_W = 11;
  localparam int CELL_W = 6;
  localparam int SPAN_W = 10;
  localparam int SHADE_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 22;
  localparam logic [SHADE_W-1:0] SHADE_X = 8'h8F;
  localparam logic [SHADE_W-1:0] SHADE_Y = 8'h4D;
  localparam logic [POS_W-1:0] DIST_MAX = {POS_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y = 3'd5;

  // Input beat opcodes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST = 1'b1;
endpackage

FILE: sv/grc_if.sv
// Valid/ready channel interfaces for the cast requests and the wall spans.
`timescale 1ns / 1ps
interface grc_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic [grc_pkg::COL_W-1:0] column;
  logic [grc_pkg::CELL_W-1:0] cell_row;
  logic [grc_pkg::CELL_W-1:0] cell_col;
  logic cell_wall;
  modport source (output valid, opcode, column, cell_row, cell_col, cell_wall, input ready);
  modport sink (input valid, opcode, column, cell_row, cell_col, cell_wall, output ready);
endinterface

interface grc_out_if;
  logic valid;
  logic ready;
  logic [grc_pkg::COL_W-1:0] column_out;
  logic [grc_pkg::SPAN_W-1:0] span_start;
  logic [grc_pkg::SPAN_W-1:0] span_end;
  logic hit_side;
  logic [grc_pkg::SHADE_W-1:0] shade;
  logic [grc_pkg::POS_W-1:0] wall_distance;
  logic escaped;
  modport source (output valid, column_out, span_start, span_end, hit_side, shade,
                  wall_distance, escaped, input ready);
  modport sink (input valid, column_out, span_start, span_end, hit_side, shade,
                wall_distance, escaped, output ready);
endinterface

FILE: sv/grc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module grc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/grid_raycast_column_unit.sv
// Top level of the grid raycast column unit: map store, sequencer and shared divider.
`timescale 1ns / 1ps
// A write-cell beat reads the addressed map row and writes it back modified. A cast beat runs
// its divisions on the shared one-bit-per-cycle divider, of width
// DW = max(clog2(MAP_DIM)+2, 8) + 32, and walks the DDA for steps <= 2*MAP_DIM, each step
// a map read and then a check. An escaping ray skips the last two divisions. One beat is
// in work at a time (ready is low meanwhile); a finished span waits in the output register.
// Synchronous reset loads the register defaults, then clears all MAP_DIM map rows.
module grid_raycast_column_unit #(
  parameter int MAP_DIM = 64,
  parameter int SCREEN_WIDTH = 1080,
  parameter int SCREEN_HEIGHT = 640
) (
  input  logic                           clk,
  input  logic                           rst_n,
  grc_in_if.sink                         in_bus,
  grc_out_if.source                      out_bus,
  input  logic                           cfg_we,
  input  logic [grc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [grc_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int F = grc_pkg::FRAC_BITS;
  localparam int AW = $clog2(MAP_DIM);
  // Cell counters must hold -1, MAP_DIM and any 6-bit start cell.
  localparam int CLW = (AW + 2 > 8) ? AW + 2 : 8;
  localparam int NW = CLW + 17;
  localparam int DW = CLW + 32;
  localparam int CNTW = $clog2(DW + 1);
  localparam int SW = $clog2(2 * MAP_DIM + 1);
  localparam int T_W = 30;
  localparam int RAY_W = 32;
  localparam int MA_W = 35;
  localparam int MB_W = 30;
  localparam int MP_W = MA_W + MB_W;
  localparam int SIDE_W = 49;
  localparam int RW = 14;
  localparam logic [SIDE_W-1:0] SIDE_INF = {SIDE_W{1'b1}};
  localparam logic [SIDE_W-1:0] SIDE_NEAR = {1'b0, {(SIDE_W-1){1'b1}}};
  localparam logic [DW-1:0] ONE_SQ = DW'(64'h1_0000_0000);
  localparam logic [DW-1:0] LH_NUM = DW'(64'(SCREEN_HEIGHT) << F);
  localparam logic [DW-1:0] DEN_W = DW'(SCREEN_WIDTH);
  localparam logic [DW-1:0] DEN_H = DW'(SCREEN_HEIGHT);
  localparam logic signed [CLW-1:0] MAP_S = CLW'(MAP_DIM);
  localparam logic [AW-1:0] CLR_LAST = AW'(MAP_DIM - 1);
  localparam logic [SW-1:0] STEP_LIMIT = SW'(2 * MAP_DIM);
  localparam logic [RW-1:0] H_R = RW'(SCREEN_HEIGHT);
  localparam logic [RW-1:0] H_LAST = RW'(SCREEN_HEIGHT - 1);
  localparam logic signed [12:0] W_S = 13'(SCREEN_WIDTH);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_WR_WB, S_T_DIV, S_MUL_X, S_MUL_Y, S_RAY_Y, S_DX_DIV, S_DY_DIV,
    S_SX_MUL, S_SY_MUL, S_SIDE_Y, S_STEP, S_CHECK, S_PD_DIV, S_LH_DIV, S_FIN
  } state_t;

  state_t state_r;

  // Camera registers.
  logic [grc_pkg::POS_W-1:0] pos_x_r, pos_y_r;
  logic [grc_pkg::DIR_W-1:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;

  // Beat registers.
  logic [grc_pkg::COL_W-1:0]  col_r;
  logic [grc_pkg::CELL_W-1:0] wr_row_r, wr_col_r;
  logic                       wr_wall_r;
  logic [AW-1:0]              clr_cnt_r;

  // Ray and walk registers.
  logic                       t_neg_r;
  logic signed [T_W-1:0]      t_r;
  logic signed [RAY_W-1:0]    rx_r, ry_r;
  logic [SIDE_W-1:0]          dx_r, dy_r, side_x_r, side_y_r;
  logic signed [CLW-1:0]      cell_x_r, cell_y_r;
  logic [SW-1:0]              steps_r;
  logic                       side_r, esc_r, dist_inf_r;
  logic [DW-1:0]              dist_r;
  logic [RW-1:0]              lh_r;
  logic signed [MP_W-1:0]     mul_r;

  // Output register.
  logic                          out_valid_r;
  logic [grc_pkg::COL_W-1:0]     out_col_r;
  logic [grc_pkg::SPAN_W-1:0]    out_start_r, out_end_r;
  logic                          out_side_r, out_esc_r;
  logic [grc_pkg::SHADE_W-1:0]   out_shade_r;
  logic [grc_pkg::POS_W-1:0]     out_dist_r;

  // Shared divider: restoring, one quotient bit per cycle.
  logic [DW-1:0]   div_quo_r, div_rem_r, div_den_r;
  logic [CNTW-1:0] div_cnt_r;
  logic            div_start, div_done;
  logic [DW-1:0]   div_num, div_den;
  logic [DW:0]     div_trial;

  // Map store.
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [MAP_DIM-1:0] ram_wdata, ram_rdata, row_mod;
  logic [AW-1:0]   wr_bit, wr_addr;

  // Datapath helpers.
  logic                     in_acc;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [12:0]       t_diff;
  logic [11:0]              t_mag;
  logic [RAY_W-1:0]         mag_x, mag_y, mag_side;
  logic [16:0]              fx, fy;
  logic                     step_sel;
  logic signed [CLW-1:0]    cx_step, cy_step, int_x, int_y;
  logic signed [NW-1:0]     pd_num, pd_abs;
  logic [RW-1:0]            start_w, end_w;
  logic                     cell_hit;

  function automatic logic [SIDE_W-1:0] sat_add(input logic [SIDE_W-1:0] a,
                                                input logic [SIDE_W-1:0] b);
    return (a == SIDE_INF || b == SIDE_INF) ? SIDE_INF : a + b;
  endfunction

  // Scaled first side distance; an infinite delta keeps the saturating semantics.
  function automatic logic [SIDE_W-1:0] side_init(input logic [16:0] fr,
                                                  input logic [SIDE_W-1:0] d,
                                                  input logic signed [MP_W-1:0] p);
    logic [SIDE_W-1:0] res;
    if (d == SIDE_INF) begin
      if (fr == 17'd0) res = '0;
      else if (fr == 17'd1) res = SIDE_NEAR;
      else res = SIDE_INF;
    end else begin
      res = SIDE_W'(p[49:16]);
    end
    return res;
  endfunction

  assign in_acc = in_bus.valid && in_bus.ready;
  assign in_bus.ready = (state_r == S_IDLE);

  assign out_bus.valid = out_valid_r;
  assign out_bus.column_out = out_col_r;
  assign out_bus.span_start = out_start_r;
  assign out_bus.span_end = out_end_r;
  assign out_bus.hit_side = out_side_r;
  assign out_bus.shade = out_shade_r;
  assign out_bus.wall_distance = out_dist_r;
  assign out_bus.escaped = out_esc_r;

  // Camera coordinate numerator 2x - SCREEN_WIDTH, split into sign and magnitude.
  assign t_diff = $signed({1'b0, in_bus.column, 1'b0}) - W_S;
  assign t_mag = t_diff[12] ? 12'(-t_diff) : t_diff[11:0];
  assign mag_x = rx_r[RAY_W-1] ? RAY_W'(-rx_r) : RAY_W'(rx_r);
  assign mag_y = ry_r[RAY_W-1] ? RAY_W'(-ry_r) : RAY_W'(ry_r);
  assign mag_side = side_r ? mag_y : mag_x;
  assign fx = rx_r[RAY_W-1] ? {1'b0, pos_x_r[F-1:0]} : 17'h10000 - {1'b0, pos_x_r[F-1:0]};
  assign fy = ry_r[RAY_W-1] ? {1'b0, pos_y_r[F-1:0]} : 17'h10000 - {1'b0, pos_y_r[F-1:0]};
  assign step_sel = (side_x_r <= side_y_r) ? 1'b0 : 1'b1;  // ties step along x
  assign cx_step = rx_r[RAY_W-1] ? cell_x_r - CLW'(1) : cell_x_r + CLW'(1);
  assign cy_step = ry_r[RAY_W-1] ? cell_y_r - CLW'(1) : cell_y_r + CLW'(1);
  assign int_x = CLW'(pos_x_r[grc_pkg::POS_W-1:F]);
  assign int_y = CLW'(pos_y_r[grc_pkg::POS_W-1:F]);
  assign cell_hit = ram_rdata[cell_y_r[AW-1:0]];
  assign wr_bit = AW'(wr_col_r);
  assign wr_addr = AW'(wr_row_r);

  // Perpendicular distance numerator: cell boundary minus position on the hit axis.
  always_comb begin
    if (side_r) begin
      pd_num = NW'({cell_y_r, 16'b0}) - NW'({1'b0, pos_y_r})
             + (ry_r[RAY_W-1] ? NW'(32'h10000) : NW'(0));
    end else begin
      pd_num = NW'({cell_x_r, 16'b0}) - NW'({1'b0, pos_x_r})
             + (rx_r[RAY_W-1] ? NW'(32'h10000) : NW'(0));
    end
    pd_abs = pd_num[NW-1] ? -pd_num : pd_num;
  end

  always_comb begin
    row_mod = ram_rdata;
    row_mod[wr_bit] = wr_wall_r;
  end

  always_comb begin
    start_w = (H_R - lh_r) >> 1;
    end_w = (lh_r + H_R) >> 1;
    if (end_w > H_LAST) begin
      end_w = H_LAST;
    end
  end

  assign div_done = (div_cnt_r == '0);

  // Sequencer-side control of the divider, the multiplier and the map port.
  always_comb begin
    div_start = 1'b0;
    div_num = '0;
    div_den = '0;
    mul_a = '0;
    mul_b = '0;
    ram_we = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
        ram_waddr = clr_cnt_r;
      end
      S_IDLE: begin
        ram_raddr = AW'(in_bus.cell_row);
        if (in_acc && in_bus.opcode == grc_pkg::OP_CAST) begin
          div_start = 1'b1;
          div_num = DW'({t_mag, 16'b0});
          div_den = DEN_W;
        end
      end
      S_WR_WB: begin
        ram_we = 1'b1;
        ram_waddr = wr_addr;
        ram_wdata = row_mod;
      end
      S_MUL_X: begin
        mul_a = MA_W'($signed(plane_x_r));
        mul_b = MB_W'(t_r);
      end
      S_MUL_Y: begin
        mul_a = MA_W'($signed(plane_y_r));
        mul_b = MB_W'(t_r);
      end
      S_RAY_Y: begin
        div_start = 1'b1;
        div_num = ONE_SQ;
        div_den = DW'(mag_x);
      end
      S_DX_DIV: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num = ONE_SQ;
          div_den = DW'(mag_y);
        end
      end
      S_SX_MUL: begin
        mul_a = $signed({1'b0, dx_r[33:0]});
        mul_b = $signed(MB_W'(fx));
      end
      S_SY_MUL: begin
        mul_a = $signed({1'b0, dy_r[33:0]});
        mul_b = $signed(MB_W'(fy));
      end
      S_STEP: begin
        ram_raddr = step_sel ? cell_x_r[AW-1:0] : cx_step[AW-1:0];
      end
      S_CHECK: begin
        if (cell_hit) begin
          div_start = 1'b1;
          div_num = {pd_abs[CLW+15:0], 16'b0};
          div_den = DW'(mag_side);
        end
      end
      S_PD_DIV: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num = LH_NUM;
          div_den = div_quo_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign div_trial = {div_rem_r, div_quo_r[DW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (div_start) begin
      div_quo_r <= div_num;
      div_rem_r <= '0;
      div_den_r <= div_den;
      div_cnt_r <= CNTW'(DW);
    end else if (!div_done) begin
      if (div_trial >= {1'b0, div_den_r}) begin
        div_rem_r <= DW'(div_trial - {1'b0, div_den_r});
        div_quo_r <= {div_quo_r[DW-2:0], 1'b1};
      end else begin
        div_rem_r <= div_trial[DW-1:0];
        div_quo_r <= {div_quo_r[DW-2:0], 1'b0};
      end
      div_cnt_r <= div_cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= MP_W'(mul_a * mul_b);
  end

  grc_ram #(
    .WIDTH(MAP_DIM),
    .DEPTH(MAP_DIM)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_cnt_r <= '0;
      out_valid_r <= 1'b0;
      pos_x_r <= '0;
      pos_y_r <= '0;
      dir_x_r <= '0;
      dir_y_r <= 18'd65536;
      plane_x_r <= 18'd43691;
      plane_y_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          grc_pkg::CFG_POS_X: pos_x_r <= cfg_data;
          grc_pkg::CFG_POS_Y: pos_y_r <= cfg_data;
          grc_pkg::CFG_DIR_X: dir_x_r <= cfg_data[grc_pkg::DIR_W-1:0];
          grc_pkg::CFG_DIR_Y: dir_y_r <= cfg_data[grc_pkg::DIR_W-1:0];
          grc_pkg::CFG_PLANE_X: plane_x_r <= cfg_data[grc_pkg::DIR_W-1:0];
          grc_pkg::CFG_PLANE_Y: plane_y_r <= cfg_data[grc_pkg::DIR_W-1:0];
          default: begin
          end
        endcase
      end

      // The final state reloads the output register itself.
      if (out_valid_r && out_bus.ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == CLR_LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            col_r <= in_bus.column;
            wr_row_r <= in_bus.cell_row;
            wr_col_r <= in_bus.cell_col;
            wr_wall_r <= in_bus.cell_wall;
            t_neg_r <= t_diff[12];
            esc_r <= 1'b0;
            if (in_bus.opcode == grc_pkg::OP_CAST) begin
              state_r <= S_T_DIV;
            end else if (32'(in_bus.cell_row) < MAP_DIM && 32'(in_bus.cell_col) < MAP_DIM) begin
              state_r <= S_WR_WB;
            end
          end
        end
        S_WR_WB: begin
          state_r <= S_IDLE;
        end
        S_T_DIV: begin
          if (div_done) begin
            t_r <= t_neg_r ? -$signed(div_quo_r[T_W-1:0]) : $signed(div_quo_r[T_W-1:0]);
            state_r <= S_MUL_X;
          end
        end
        S_MUL_X: begin
          state_r <= S_MUL_Y;
        end
        S_MUL_Y: begin
          rx_r <= RAY_W'($signed(dir_x_r)) + RAY_W'(mul_r >>> F);
          state_r <= S_RAY_Y;
        end
        S_RAY_Y: begin
          ry_r <= RAY_W'($signed(dir_y_r)) + RAY_W'(mul_r >>> F);
          state_r <= S_DX_DIV;
        end
        S_DX_DIV: begin
          if (div_done) begin
            dx_r <= (mag_x == '0) ? SIDE_INF : SIDE_W'(div_quo_r);
            state_r <= S_DY_DIV;
          end
        end
        S_DY_DIV: begin
          if (div_done) begin
            dy_r <= (mag_y == '0) ? SIDE_INF : SIDE_W'(div_quo_r);
            state_r <= S_SX_MUL;
          end
        end
        S_SX_MUL: begin
          state_r <= S_SY_MUL;
        end
        S_SY_MUL: begin
          side_x_r <= side_init(fx, dx_r, mul_r);
          state_r <= S_SIDE_Y;
        end
        S_SIDE_Y: begin
          side_y_r <= side_init(fy, dy_r, mul_r);
          cell_x_r <= int_x;
          cell_y_r <= int_y;
          steps_r <= '0;
          // A start cell off the map escapes before the first step.
          if (int_x >= MAP_S || int_y >= MAP_S) begin
            esc_r <= 1'b1;
            state_r <= S_FIN;
          end else begin
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          side_r <= step_sel;
          steps_r <= steps_r + SW'(1);
          if (!step_sel) begin
            side_x_r <= sat_add(side_x_r, dx_r);
            cell_x_r <= cx_step;
            if (cx_step < 0 || cx_step >= MAP_S) begin
              esc_r <= 1'b1;
              state_r <= S_FIN;
            end else begin
              state_r <= S_CHECK;
            end
          end else begin
            side_y_r <= sat_add(side_y_r, dy_r);
            cell_y_r <= cy_step;
            if (cy_step < 0 || cy_step >= MAP_S) begin
              esc_r <= 1'b1;
              state_r <= S_FIN;
            end else begin
              state_r <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (cell_hit) begin
            dist_inf_r <= (mag_side == '0);
            state_r <= S_PD_DIV;
          end else if (steps_r == STEP_LIMIT) begin
            esc_r <= 1'b1;
            state_r <= S_FIN;
          end else begin
            state_r <= S_STEP;
          end
        end
        S_PD_DIV: begin
          if (div_done) begin
            dist_r <= div_quo_r;
            state_r <= S_LH_DIV;
          end
        end
        S_LH_DIV: begin
          if (div_done) begin
            // An infinite distance gives no height; a zero distance gives the full span.
            if (dist_inf_r) begin
              lh_r <= '0;
            end else if (dist_r == '0 || div_quo_r > DEN_H) begin
              lh_r <= H_R;
            end else begin
              lh_r <= RW'(div_quo_r);
            end
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_bus.ready) begin
            out_valid_r <= 1'b1;
            out_col_r <= col_r;
            out_esc_r <= esc_r;
            if (esc_r) begin
              out_start_r <= '0;
              out_end_r <= '0;
              out_side_r <= 1'b0;
              out_shade_r <= '0;
              out_dist_r <= grc_pkg::DIST_MAX;
            end else begin
              out_start_r <= start_w[grc_pkg::SPAN_W-1:0];
              out_end_r <= end_w[grc_pkg::SPAN_W-1:0];
              out_side_r <= side_r;
              out_shade_r <= side_r ? grc_pkg::SHADE_Y : grc_pkg::SHADE_X;
              out_dist_r <= (dist_inf_r || dist_r > DW'(grc_pkg::DIST_MAX))
                          ? grc_pkg::DIST_MAX : dist_r[grc_pkg::POS_W-1:0];
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end
endmodule
